### design/s3m_pattern_event_unpacker_core_assert.svh
// Assertion macros for the pattern event unpacker.
// Each macro expects signals named clk and rst in the scope of use.
`ifndef S3M_PATTERN_EVENT_UNPACKER_CORE_ASSERT_SVH
`define S3M_PATTERN_EVENT_UNPACKER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// Implication checked on every clock edge outside reset
`define S3MPU_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("s3mpu assertion failed");

// Implication whose consequence is checked in the next cycle
`define S3MPU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("s3mpu assertion failed");

`else

`define S3MPU_ASSERT_IMPL(lbl, ante, cons)
`define S3MPU_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### design/s3mpu_pkg.sv
package s3mpu_pkg;

  // Parse phase of the front end
  typedef enum logic [2:0] {
    PH_MASK,
    PH_NOTE,
    PH_INST,
    PH_VOL,
    PH_CODE,
    PH_INFO
  } phase_t;

  // Mask byte bits
  localparam int MASK_NOTE_BIT = 5;
  localparam int MASK_VOL_BIT  = 6;
  localparam int MASK_FX_BIT   = 7;

  // Special note bytes and decoded values
  localparam logic [7:0] NOTE_IN_EMPTY = 8'd255;
  localparam logic [7:0] NOTE_IN_OFF   = 8'd254;
  localparam logic [7:0] NOTE_OFF      = 8'd255;

  // Effect codes (A = 1 ... U = 21)
  localparam logic [7:0] FX_A = 8'd1;
  localparam logic [7:0] FX_B = 8'd2;
  localparam logic [7:0] FX_C = 8'd3;
  localparam logic [7:0] FX_D = 8'd4;
  localparam logic [7:0] FX_E = 8'd5;
  localparam logic [7:0] FX_F = 8'd6;
  localparam logic [7:0] FX_G = 8'd7;
  localparam logic [7:0] FX_H = 8'd8;
  localparam logic [7:0] FX_I = 8'd9;
  localparam logic [7:0] FX_J = 8'd10;
  localparam logic [7:0] FX_K = 8'd11;
  localparam logic [7:0] FX_L = 8'd12;
  localparam logic [7:0] FX_O = 8'd15;
  localparam logic [7:0] FX_Q = 8'd17;
  localparam logic [7:0] FX_R = 8'd18;
  localparam logic [7:0] FX_S = 8'd19;
  localparam logic [7:0] FX_T = 8'd20;
  localparam logic [7:0] FX_U = 8'd21;

  // S subcommands (high nibble of info)
  localparam logic [3:0] SX_FINETUNE = 4'd2;
  localparam logic [3:0] SX_PAN      = 4'd8;
  localparam logic [3:0] SX_SURROUND = 4'd10;
  localparam logic [3:0] SX_LOOP     = 4'd11;
  localparam logic [3:0] SX_CUT      = 4'd12;
  localparam logic [3:0] SX_DELAY    = 4'd14;

  // Dense command kinds
  localparam logic [4:0] KIND_NONE       = 5'd0;
  localparam logic [4:0] KIND_SPEED      = 5'd1;
  localparam logic [4:0] KIND_GOTO       = 5'd2;
  localparam logic [4:0] KIND_VOLSLIDE   = 5'd3;
  localparam logic [4:0] KIND_SLIDE_DOWN = 5'd4;
  localparam logic [4:0] KIND_SLIDE_UP   = 5'd5;
  localparam logic [4:0] KIND_PORTA      = 5'd6;
  localparam logic [4:0] KIND_VIBRATO    = 5'd7;
  localparam logic [4:0] KIND_TREMOR     = 5'd8;
  localparam logic [4:0] KIND_ARPEGGIO   = 5'd9;
  localparam logic [4:0] KIND_VSL_VIB    = 5'd10;
  localparam logic [4:0] KIND_PORTA_VSL  = 5'd11;
  localparam logic [4:0] KIND_OFFSET     = 5'd12;
  localparam logic [4:0] KIND_RETRIG     = 5'd13;
  localparam logic [4:0] KIND_TREMOLO    = 5'd14;
  localparam logic [4:0] KIND_FINETUNE   = 5'd15;
  localparam logic [4:0] KIND_PAN        = 5'd16;
  localparam logic [4:0] KIND_LOOP_SET   = 5'd17;
  localparam logic [4:0] KIND_LOOP_DO    = 5'd18;
  localparam logic [4:0] KIND_NOTE_CUT   = 5'd19;
  localparam logic [4:0] KIND_PAT_DELAY  = 5'd20;
  localparam logic [4:0] KIND_TEMPO      = 5'd21;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = 1;
  localparam int QUEUE_CNT_W = 2;

  // Request from the front end: a finished event or an end-of-pattern mark
  typedef struct packed {
    logic              done;
    logic [5:0]        row;
    logic [4:0]        channel;
    logic [7:0]        note;
    logic              trigger;
    logic signed [8:0] instrument;
    logic signed [8:0] volume;
    logic [7:0]        fx_code;
    logic [7:0]        fx_info;
  } req_t;

  // Result as shown on the output channel
  typedef struct packed {
    logic               event_valid;
    logic               pattern_done;
    logic [5:0]         row_index;
    logic [4:0]         channel_index;
    logic [7:0]         note_value;
    logic               note_trigger;
    logic signed [8:0]  instrument;
    logic signed [8:0]  volume;
    logic [4:0]         command_kind;
    logic signed [16:0] command_arg1;
    logic signed [8:0]  command_arg2;
  } res_t;

endpackage

### design/s3mpu_front.sv
module s3mpu_front #(
  parameter int ROWS_PER_PATTERN = 64,
  parameter int ROW_W            = 7
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             byte_valid,
  input  logic [7:0]       data_byte,
  input  logic             pattern_start,
  input  logic [7:0]       sample_count,
  output logic             push,
  output s3mpu_pkg::req_t  push_req
);

  localparam logic [ROW_W-1:0] ROWS_END = ROW_W'(ROWS_PER_PATTERN);

  s3mpu_pkg::phase_t phase, phase_next, phase_eff;
  logic [7:0]        mask, mask_next;
  logic [ROW_W-1:0]  row_cnt, row_next, row_eff, row_inc;
  logic [7:0]        note, note_next;
  logic              trig, trig_next;
  logic signed [8:0] inst, inst_next;
  logic signed [8:0] vol, vol_next;
  logic [7:0]        code, code_next;
  logic              active;
  logic              emit;
  logic              done;
  logic [7:0]        note_dec;
  logic [7:0]        inst_clamp;

  // Phase that follows the instrument byte (or a mask without note bit)
  function automatic s3mpu_pkg::phase_t after_inst(input logic [7:0] m);
    if (m[s3mpu_pkg::MASK_VOL_BIT]) return s3mpu_pkg::PH_VOL;
    if (m[s3mpu_pkg::MASK_FX_BIT])  return s3mpu_pkg::PH_CODE;
    return s3mpu_pkg::PH_MASK;
  endfunction

  // Decoded note: octave * 12 + semitone
  assign note_dec = 8'(data_byte[3:0]) + {1'b0, data_byte[7:4], 3'b000}
                  + {2'b00, data_byte[7:4], 2'b00};
  assign inst_clamp = (data_byte > sample_count) ? sample_count : data_byte;

  // Start of pattern overrides row and phase before the byte is parsed
  assign row_eff   = pattern_start ? '0 : row_cnt;
  assign phase_eff = pattern_start ? s3mpu_pkg::PH_MASK : phase;
  assign active    = row_eff < ROWS_END;
  assign row_inc   = row_eff + ROW_W'(1);

  // Next state of the parser
  always_comb begin
    phase_next = phase_eff;
    mask_next  = mask;
    row_next   = row_eff;
    note_next  = note;
    trig_next  = trig;
    inst_next  = inst;
    vol_next   = vol;
    code_next  = code;
    emit       = 1'b0;
    done       = 1'b0;
    if (active) begin
      case (phase_eff)
        s3mpu_pkg::PH_NOTE: begin
          if (data_byte == s3mpu_pkg::NOTE_IN_EMPTY) begin
            note_next = '0;
            trig_next = 1'b0;
          end else if (data_byte == s3mpu_pkg::NOTE_IN_OFF) begin
            note_next = s3mpu_pkg::NOTE_OFF;
            trig_next = 1'b0;
          end else begin
            note_next = note_dec;
            trig_next = 1'b1;
          end
          phase_next = s3mpu_pkg::PH_INST;
        end
        s3mpu_pkg::PH_INST: begin
          inst_next  = $signed({1'b0, inst_clamp}) - 9'sd1;
          phase_next = after_inst(mask);
          emit       = (after_inst(mask) == s3mpu_pkg::PH_MASK);
        end
        s3mpu_pkg::PH_VOL: begin
          vol_next = $signed({1'b0, data_byte});
          if (mask[s3mpu_pkg::MASK_FX_BIT]) begin
            phase_next = s3mpu_pkg::PH_CODE;
          end else begin
            phase_next = s3mpu_pkg::PH_MASK;
            emit       = 1'b1;
          end
        end
        s3mpu_pkg::PH_CODE: begin
          code_next  = data_byte;
          phase_next = s3mpu_pkg::PH_INFO;
        end
        s3mpu_pkg::PH_INFO: begin
          phase_next = s3mpu_pkg::PH_MASK;
          emit       = 1'b1;
        end
        default: begin
          if (data_byte == 8'd0) begin
            // empty mask ends the row
            phase_next = s3mpu_pkg::PH_MASK;
            row_next   = row_inc;
            done       = (row_inc >= ROWS_END);
          end else begin
            mask_next = data_byte;
            note_next = '0;
            trig_next = 1'b0;
            inst_next = -9'sd1;
            vol_next  = -9'sd1;
            code_next = '0;
            if (data_byte[s3mpu_pkg::MASK_NOTE_BIT]) begin
              phase_next = s3mpu_pkg::PH_NOTE;
            end else begin
              phase_next = after_inst(data_byte);
              emit       = (after_inst(data_byte) == s3mpu_pkg::PH_MASK);
            end
          end
        end
      endcase
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= s3mpu_pkg::PH_MASK;
      mask    <= '0;
      row_cnt <= ROWS_END;
      note    <= '0;
      trig    <= 1'b0;
      inst    <= -9'sd1;
      vol     <= -9'sd1;
      code    <= '0;
    end else if (byte_valid) begin
      phase   <= phase_next;
      mask    <= mask_next;
      row_cnt <= row_next;
      note    <= note_next;
      trig    <= trig_next;
      inst    <= inst_next;
      vol     <= vol_next;
      code    <= code_next;
    end
  end

  // Request towards the queue
  always_comb begin
    push_req.done       = done;
    push_req.row        = done ? 6'd0 : 6'(row_eff);
    push_req.channel    = done ? 5'd0 : mask_next[4:0];
    push_req.note       = done ? 8'd0 : note_next;
    push_req.trigger    = done ? 1'b0 : trig_next;
    push_req.instrument = done ? -9'sd1 : inst_next;
    push_req.volume     = done ? -9'sd1 : vol_next;
    push_req.fx_code    = done ? 8'd0 : code_next;
    push_req.fx_info    = data_byte;
  end

  assign push = byte_valid && (emit || done);

endmodule

### design/s3mpu_queue.sv
module s3mpu_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  s3mpu_pkg::req_t push_req,
  input  logic            pop,
  output logic            q_valid,
  output logic            q_full,
  output s3mpu_pkg::req_t q_req
);

  s3mpu_pkg::req_t                  entries [s3mpu_pkg::QUEUE_DEPTH];
  logic [s3mpu_pkg::QUEUE_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [s3mpu_pkg::QUEUE_CNT_W-1:0] count;

  assign q_valid = (count != '0);
  assign q_full  = (count == s3mpu_pkg::QUEUE_CNT_W'(s3mpu_pkg::QUEUE_DEPTH));
  assign q_req   = entries[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_req;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + s3mpu_pkg::QUEUE_CNT_W'(1);
        2'b01:   count <= count - s3mpu_pkg::QUEUE_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

### design/s3mpu_back.sv
module s3mpu_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  s3mpu_pkg::req_t q_req,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output s3mpu_pkg::res_t out_res
);

  logic [3:0]  fx_x, fx_y;
  logic [7:0]  fx_z;
  logic [4:0]  kind;
  logic [16:0] arg1;
  logic [8:0]  arg2;
  logic        trig_clr;
  logic        load;

  assign fx_x = q_req.fx_info[7:4];
  assign fx_y = q_req.fx_info[3:0];
  assign fx_z = q_req.fx_info;

  // Effect translation into dense kind and arguments
  always_comb begin
    kind     = s3mpu_pkg::KIND_NONE;
    arg1     = '0;
    arg2     = '0;
    trig_clr = 1'b0;
    case (q_req.fx_code)
      s3mpu_pkg::FX_A: begin
        kind = s3mpu_pkg::KIND_SPEED;
        arg1 = (fx_z != 8'd0) ? 17'(fx_z) : 17'd1;
      end
      s3mpu_pkg::FX_B: begin
        kind = s3mpu_pkg::KIND_GOTO;
        arg1 = 17'(fx_z);
        arg2 = '1;
      end
      s3mpu_pkg::FX_C: begin
        // break row given in decimal digits
        kind = s3mpu_pkg::KIND_GOTO;
        arg1 = '1;
        arg2 = 9'(fx_x) * 9'd10 + 9'(fx_y);
      end
      s3mpu_pkg::FX_D: begin
        kind = s3mpu_pkg::KIND_VOLSLIDE;
        arg1 = 17'(fx_x);
        arg2 = 9'(fx_y);
      end
      s3mpu_pkg::FX_E: begin
        kind = s3mpu_pkg::KIND_SLIDE_DOWN;
        arg1 = 17'(fx_x);
        arg2 = 9'(fx_y);
      end
      s3mpu_pkg::FX_F: begin
        kind = s3mpu_pkg::KIND_SLIDE_UP;
        arg1 = 17'(fx_x);
        arg2 = 9'(fx_y);
      end
      s3mpu_pkg::FX_G: begin
        kind     = s3mpu_pkg::KIND_PORTA;
        arg1     = 17'({fx_z, 2'b00});
        arg2     = 9'(q_req.note);
        trig_clr = 1'b1;
      end
      s3mpu_pkg::FX_H: begin
        kind = s3mpu_pkg::KIND_VIBRATO;
        arg1 = 17'(fx_x);
        arg2 = 9'({fx_y, 2'b00});
      end
      s3mpu_pkg::FX_I: begin
        kind = s3mpu_pkg::KIND_TREMOR;
        arg1 = 17'(fx_x);
        arg2 = 9'(fx_y);
      end
      s3mpu_pkg::FX_J: begin
        kind = s3mpu_pkg::KIND_ARPEGGIO;
        arg1 = 17'(fx_x);
        arg2 = 9'(fx_y);
      end
      s3mpu_pkg::FX_K: begin
        kind = s3mpu_pkg::KIND_VSL_VIB;
        arg1 = (fx_x != 4'd0) ? 17'(fx_x) : 17'd0 - 17'(fx_y);
      end
      s3mpu_pkg::FX_L: begin
        kind     = s3mpu_pkg::KIND_PORTA_VSL;
        arg1     = (fx_x != 4'd0) ? 17'(fx_x) : 17'd0 - 17'(fx_y);
        trig_clr = 1'b1;
      end
      s3mpu_pkg::FX_O: begin
        kind = s3mpu_pkg::KIND_OFFSET;
        arg1 = 17'({fx_z, 8'h00});
      end
      s3mpu_pkg::FX_Q: begin
        kind = s3mpu_pkg::KIND_RETRIG;
        arg1 = 17'(fx_x);
        arg2 = 9'(fx_y);
      end
      s3mpu_pkg::FX_R: begin
        kind = s3mpu_pkg::KIND_TREMOLO;
        arg1 = 17'(fx_x);
        arg2 = 9'(fx_y);
      end
      s3mpu_pkg::FX_S: begin
        case (fx_x)
          s3mpu_pkg::SX_FINETUNE: begin
            kind = s3mpu_pkg::KIND_FINETUNE;
            arg1 = {{13{fx_y[3]}}, fx_y};
          end
          s3mpu_pkg::SX_PAN: begin
            // y * 255 / 15 is y * 17
            kind = s3mpu_pkg::KIND_PAN;
            arg1 = 17'({fx_y, fx_y});
          end
          s3mpu_pkg::SX_SURROUND: begin
            // nibble shifted by eight, wrapping: flip bit 3
            kind = s3mpu_pkg::KIND_PAN;
            arg1 = 17'({~fx_y[3], fx_y[2:0], ~fx_y[3], fx_y[2:0]});
          end
          s3mpu_pkg::SX_LOOP: begin
            if (fx_y == 4'd0) begin
              kind = s3mpu_pkg::KIND_LOOP_SET;
            end else begin
              kind = s3mpu_pkg::KIND_LOOP_DO;
              arg1 = 17'(fx_y);
            end
          end
          s3mpu_pkg::SX_CUT: begin
            kind = s3mpu_pkg::KIND_NOTE_CUT;
            arg1 = 17'(fx_y);
          end
          s3mpu_pkg::SX_DELAY: begin
            kind = s3mpu_pkg::KIND_PAT_DELAY;
            arg1 = 17'(fx_y);
          end
          default: begin
            kind = s3mpu_pkg::KIND_NONE;
          end
        endcase
      end
      s3mpu_pkg::FX_T: begin
        kind = s3mpu_pkg::KIND_TEMPO;
        arg1 = 17'(fx_z);
      end
      s3mpu_pkg::FX_U: begin
        kind = s3mpu_pkg::KIND_VIBRATO;
        arg1 = 17'(fx_x);
        arg2 = 9'(fx_y);
      end
      default: begin
        kind = s3mpu_pkg::KIND_NONE;
      end
    endcase
  end

  // Output register takes a request when empty or being drained
  assign load = q_valid && (!out_valid || out_ready);
  assign pop  = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res.event_valid   <= !q_req.done;
      out_res.pattern_done  <= q_req.done;
      out_res.row_index     <= q_req.row;
      out_res.channel_index <= q_req.channel;
      out_res.note_value    <= q_req.note;
      out_res.note_trigger  <= q_req.trigger && !trig_clr;
      out_res.instrument    <= q_req.instrument;
      out_res.volume        <= q_req.volume;
      out_res.command_kind  <= kind;
      out_res.command_arg1  <= $signed(arg1);
      out_res.command_arg2  <= $signed(arg2);
    end
  end

endmodule

### design/s3m_pattern_event_unpacker_core.sv
// Packed pattern decoder for tracker module data. Feed one pattern byte per
// request on the s_ side (tuser marks the first byte of a pattern) and
// receive one result per completed channel event, plus one end-of-pattern
// result (tlast high, tuser low) once the row count reaches ROWS_PER_PATTERN.
// Bytes are taken one per cycle while the queue is not full; a result goes
// from the queue entry through the output register to the m_ side. A
// two-entry queue sits between the byte parser and the effect translator,
// which feeds the output register, so input is only held off when both are
// full under output backpressure. sample_count is set through cfg_wr_en /
// cfg_wr_data; the user must write it only while the stream is idle, which
// the block itself does not enforce. It resets to 99.
`include "s3m_pattern_event_unpacker_core_assert.svh"

module s3m_pattern_event_unpacker_core #(
  parameter int ROWS_PER_PATTERN = 64
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  // byte stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic [0:0]  s_tuser,   // [0] pattern_start
  // event stream
  output logic        m_tvalid,
  input  logic        m_tready,
  // [5:0] row_index, [10:6] channel_index, [18:11] note_value,
  // [19] note_trigger, [28:20] instrument, [37:29] volume,
  // [42:38] command_kind, [59:43] command_arg1, [68:60] command_arg2,
  // [71:69] zero
  output logic [71:0] m_tdata,
  output logic        m_tlast,   // pattern_done
  output logic [0:0]  m_tuser    // [0] event_valid
);

  localparam int ROW_W = $clog2(ROWS_PER_PATTERN + 1);

  logic [7:0]      sample_cnt;
  logic            push, pop, q_valid, q_full;
  logic            byte_acc;
  s3mpu_pkg::req_t push_req, q_req;
  s3mpu_pkg::res_t res;

  // Instrument count register
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_cnt <= 8'd99;
    end else if (cfg_wr_en) begin
      sample_cnt <= cfg_wr_data;
    end
  end

  assign s_tready = !q_full;
  assign byte_acc = s_tvalid && s_tready;

  // Byte parser
  s3mpu_front #(
    .ROWS_PER_PATTERN (ROWS_PER_PATTERN),
    .ROW_W            (ROW_W)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .byte_valid    (byte_acc),
    .data_byte     (s_tdata),
    .pattern_start (s_tuser[0]),
    .sample_count  (sample_cnt),
    .push          (push),
    .push_req      (push_req)
  );

  // Request queue
  s3mpu_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_req (push_req),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_full   (q_full),
    .q_req    (q_req)
  );

  // Effect translation and output register
  s3mpu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_req     (q_req),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  assign m_tdata = {3'b000, res.command_arg2, res.command_arg1, res.command_kind,
                    res.volume, res.instrument, res.note_trigger, res.note_value,
                    res.channel_index, res.row_index};
  assign m_tlast = res.pattern_done;
  assign m_tuser = res.event_valid;

  // Checks
  `S3MPU_ASSERT_IMPL(a_no_overflow, push, !q_full)
  `S3MPU_ASSERT_IMPL(a_no_underflow, pop, q_valid)
  `S3MPU_ASSERT_IMPL(a_done_not_event, m_tvalid && m_tlast, !m_tuser[0] && !res.event_valid)
  `S3MPU_ASSERT_NEXT(a_kind_range, pop, m_tvalid && res.command_kind <= s3mpu_pkg::KIND_TEMPO)

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int ROWS = 64;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_BYTES = 30;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } byte_req_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // [7:0] data_byte
  logic [0:0]  s_tuser = '0;   // [0] pattern_start
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // [5:0] row, [10:6] channel, [18:11] note, [19] trigger, [28:20] instrument,
  // [37:29] volume, [42:38] kind, [59:43] arg1, [68:60] arg2
  logic [71:0] m_tdata;
  logic        m_tlast;        // pattern_done
  logic [0:0]  m_tuser;        // [0] event_valid

  // byte requests still to be driven, and decoded events still to arrive
  byte_req_t         pending_bytes[$];
  s3mpu_pkg::res_t   pending_events[$];
  int                bytes_queued = 0;
  int                bytes_taken = 0;
  int                mismatches = 0;
  int                cycle_count = 0;
  bit                quiet = 1'b0;
  int                s_gap = 0;
  int                m_gap = 0;

  // decoder state as the block should hold it
  s3mpu_pkg::phase_t parse_ph = s3mpu_pkg::PH_MASK;
  logic [7:0]        mask_b = '0;
  int                row_cnt = ROWS;
  logic [7:0]        held_note = '0;
  bit                held_trig = 1'b0;
  int                held_inst = -1;
  int                held_vol = -1;
  logic [7:0]        held_code = '0;
  logic [7:0]        sample_cnt = 8'd99;

  s3m_pattern_event_unpacker_core #(
    .ROWS_PER_PATTERN(ROWS)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .m_tuser     (m_tuser)
  );

  always #6 clk = ~clk;

  // what follows the instrument byte, going by the mask
  function automatic void after_inst(output s3mpu_pkg::phase_t nxt, output bit emit);
    emit = 1'b0;
    nxt = s3mpu_pkg::PH_MASK;
    if (mask_b[s3mpu_pkg::MASK_VOL_BIT]) nxt = s3mpu_pkg::PH_VOL;
    else if (mask_b[s3mpu_pkg::MASK_FX_BIT]) nxt = s3mpu_pkg::PH_CODE;
    else emit = 1'b1;
  endfunction

  // effect code and info byte to dense command kind and arguments
  function automatic void translate_fx(input logic [7:0] code, input logic [7:0] info,
                                       output int kind, output int a1, output int a2);
    int x;
    int y;
    int z;
    x = info[7:4];
    y = info[3:0];
    z = info;
    kind = s3mpu_pkg::KIND_NONE;
    a1 = 0;
    a2 = 0;
    case (code)
      s3mpu_pkg::FX_A: begin kind = s3mpu_pkg::KIND_SPEED; a1 = (z != 0) ? z : 1; end
      s3mpu_pkg::FX_B: begin kind = s3mpu_pkg::KIND_GOTO; a1 = z; a2 = -1; end
      s3mpu_pkg::FX_C: begin kind = s3mpu_pkg::KIND_GOTO; a1 = -1; a2 = x * 10 + y; end
      s3mpu_pkg::FX_D: begin kind = s3mpu_pkg::KIND_VOLSLIDE; a1 = x; a2 = y; end
      s3mpu_pkg::FX_E: begin kind = s3mpu_pkg::KIND_SLIDE_DOWN; a1 = x; a2 = y; end
      s3mpu_pkg::FX_F: begin kind = s3mpu_pkg::KIND_SLIDE_UP; a1 = x; a2 = y; end
      s3mpu_pkg::FX_G: begin
        kind = s3mpu_pkg::KIND_PORTA;
        a1 = z * 4;
        a2 = held_note;
        held_trig = 1'b0;
      end
      s3mpu_pkg::FX_H: begin kind = s3mpu_pkg::KIND_VIBRATO; a1 = x; a2 = y * 4; end
      s3mpu_pkg::FX_I: begin kind = s3mpu_pkg::KIND_TREMOR; a1 = x; a2 = y; end
      s3mpu_pkg::FX_J: begin kind = s3mpu_pkg::KIND_ARPEGGIO; a1 = x; a2 = y; end
      s3mpu_pkg::FX_K: begin kind = s3mpu_pkg::KIND_VSL_VIB; a1 = (x != 0) ? x : -y; end
      s3mpu_pkg::FX_L: begin
        kind = s3mpu_pkg::KIND_PORTA_VSL;
        a1 = (x != 0) ? x : -y;
        held_trig = 1'b0;
      end
      s3mpu_pkg::FX_O: begin kind = s3mpu_pkg::KIND_OFFSET; a1 = z * 256; end
      s3mpu_pkg::FX_Q: begin kind = s3mpu_pkg::KIND_RETRIG; a1 = x; a2 = y; end
      s3mpu_pkg::FX_R: begin kind = s3mpu_pkg::KIND_TREMOLO; a1 = x; a2 = y; end
      s3mpu_pkg::FX_S: begin
        case (info[7:4])
          s3mpu_pkg::SX_FINETUNE: begin
            kind = s3mpu_pkg::KIND_FINETUNE;
            a1 = (y >= 8) ? y - 16 : y;
          end
          s3mpu_pkg::SX_PAN: begin kind = s3mpu_pkg::KIND_PAN; a1 = y * 255 / 15; end
          s3mpu_pkg::SX_SURROUND: begin
            kind = s3mpu_pkg::KIND_PAN;
            a1 = ((y > 7) ? y - 8 : y + 8) * 255 / 15;
          end
          s3mpu_pkg::SX_LOOP: begin
            if (y == 0) kind = s3mpu_pkg::KIND_LOOP_SET;
            else begin kind = s3mpu_pkg::KIND_LOOP_DO; a1 = y; end
          end
          s3mpu_pkg::SX_CUT: begin kind = s3mpu_pkg::KIND_NOTE_CUT; a1 = y; end
          s3mpu_pkg::SX_DELAY: begin kind = s3mpu_pkg::KIND_PAT_DELAY; a1 = y; end
          default: ;
        endcase
      end
      s3mpu_pkg::FX_T: begin kind = s3mpu_pkg::KIND_TEMPO; a1 = z; end
      s3mpu_pkg::FX_U: begin kind = s3mpu_pkg::KIND_VIBRATO; a1 = x; a2 = y; end
      default: ;
    endcase
  endfunction

  // take one accepted byte request and queue the result it completes, if any
  function automatic void unpack_byte(input logic [7:0] b, input logic start);
    s3mpu_pkg::phase_t nxt;
    bit                emit;
    int                kind;
    int                a1;
    int                a2;
    s3mpu_pkg::res_t   r;
    logic [7:0]        v;
    nxt = s3mpu_pkg::PH_MASK;
    emit = 1'b0;
    kind = s3mpu_pkg::KIND_NONE;
    a1 = 0;
    a2 = 0;
    v = b;
    if (start) begin
      row_cnt = 0;
      parse_ph = s3mpu_pkg::PH_MASK;
    end
    if (row_cnt >= ROWS) return;
    case (parse_ph)
      s3mpu_pkg::PH_NOTE: begin
        if (v == s3mpu_pkg::NOTE_IN_EMPTY) begin
          held_note = '0;
          held_trig = 1'b0;
        end else if (v == s3mpu_pkg::NOTE_IN_OFF) begin
          held_note = s3mpu_pkg::NOTE_OFF;
          held_trig = 1'b0;
        end else begin
          held_note = 8'(v[3:0] + 12 * v[7:4]);
          held_trig = 1'b1;
        end
        nxt = s3mpu_pkg::PH_INST;
      end
      s3mpu_pkg::PH_INST: begin
        if (v > sample_cnt) v = sample_cnt;
        held_inst = int'(v) - 1;
        after_inst(nxt, emit);
      end
      s3mpu_pkg::PH_VOL: begin
        held_vol = v;
        if (mask_b[s3mpu_pkg::MASK_FX_BIT]) nxt = s3mpu_pkg::PH_CODE;
        else emit = 1'b1;
      end
      s3mpu_pkg::PH_CODE: begin
        held_code = v;
        nxt = s3mpu_pkg::PH_INFO;
      end
      s3mpu_pkg::PH_INFO: begin
        if (held_code != 0) translate_fx(held_code, v, kind, a1, a2);
        emit = 1'b1;
      end
      default: begin
        // zero mask: next row, end of pattern at the last one
        if (v == 0) begin
          parse_ph = s3mpu_pkg::PH_MASK;
          row_cnt++;
          if (row_cnt >= ROWS) begin
            r = '0;
            r.pattern_done = 1'b1;
            r.instrument = '1;
            r.volume = '1;
            pending_events.push_back(r);
          end
          return;
        end
        mask_b = v;
        held_note = '0;
        held_trig = 1'b0;
        held_inst = -1;
        held_vol = -1;
        held_code = '0;
        if (v[s3mpu_pkg::MASK_NOTE_BIT]) nxt = s3mpu_pkg::PH_NOTE;
        else after_inst(nxt, emit);
      end
    endcase
    if (emit) begin
      parse_ph = s3mpu_pkg::PH_MASK;
      r.event_valid = 1'b1;
      r.pattern_done = 1'b0;
      r.row_index = row_cnt[5:0];
      r.channel_index = mask_b[4:0];
      r.note_value = held_note;
      r.note_trigger = held_trig;
      r.instrument = held_inst[8:0];
      r.volume = held_vol[8:0];
      r.command_kind = kind[4:0];
      r.command_arg1 = a1[16:0];
      r.command_arg2 = a2[8:0];
      pending_events.push_back(r);
    end else begin
      parse_ph = nxt;
    end
  endfunction

  function automatic void queue_byte(input logic [7:0] d, input logic s);
    pending_bytes.push_back('{data: d, start: s});
    bytes_queued++;
  endfunction

  // one channel event with random content; when cut, only its first bytes go out
  function automatic void queue_event(input bit first, input bit cut);
    logic [7:0] ev[$];
    logic [7:0] mask;
    logic [7:0] code;
    logic [7:0] info;
    int         n;
    int         sel;
    mask = 8'($urandom_range(1, 255));
    ev.push_back(mask);
    if (mask[s3mpu_pkg::MASK_NOTE_BIT]) begin
      sel = $urandom_range(0, 9);
      if (sel == 0) ev.push_back(s3mpu_pkg::NOTE_IN_EMPTY);
      else if (sel == 1) ev.push_back(s3mpu_pkg::NOTE_IN_OFF);
      else if (sel == 2) ev.push_back(8'($urandom_range(0, 253)));
      else ev.push_back({4'($urandom_range(0, 9)), 4'($urandom_range(0, 15))});
      ev.push_back(8'($urandom_range(0, 255)));
    end
    if (mask[s3mpu_pkg::MASK_VOL_BIT]) ev.push_back(8'($urandom_range(0, 255)));
    if (mask[s3mpu_pkg::MASK_FX_BIT]) begin
      sel = $urandom_range(0, 9);
      if (sel < 3) code = s3mpu_pkg::FX_S;
      else if (sel < 9) code = 8'($urandom_range(s3mpu_pkg::FX_A, s3mpu_pkg::FX_U));
      else code = 8'($urandom_range(0, 255));
      info = 8'($urandom_range(0, 255));
      if (code == s3mpu_pkg::FX_S && $urandom_range(0, 3) != 0)
        info[7:4] = 4'($urandom_range(s3mpu_pkg::SX_FINETUNE, s3mpu_pkg::SX_DELAY));
      ev.push_back(code);
      ev.push_back(info);
    end
    n = ev.size();
    if (cut && n > 1) n = $urandom_range(1, n - 1);
    for (int i = 0; i < n; i++) queue_byte(ev[i], first && i == 0);
  endfunction

  // a pattern of some rows, each with up to density events
  function automatic void queue_pattern(input int rows, input int density);
    int n;
    for (int r = 0; r < rows; r++) begin
      n = $urandom_range(0, density);
      for (int e = 0; e < n; e++) queue_event(r == 0 && e == 0, 1'b0);
      queue_byte(8'h00, r == 0 && n == 0);
    end
  endfunction

  task automatic wait_idle();
    while (bytes_taken != bytes_queued || pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_sample_count(input logic [7:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    sample_cnt = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // byte request driver
  always @(posedge clk) begin : drive
    byte_req_t req;
    bit        next_valid;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_gap = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        unpack_byte(s_tdata, s_tuser[0]);
        bytes_taken++;
      end
      if (!s_tvalid || s_tready) begin
        next_valid = 1'b0;
        if (s_gap > 0) begin
          s_gap--;
        end else if (pending_bytes.size() != 0) begin
          if (!quiet && $urandom_range(0, 5) == 0) begin
            s_gap = $urandom_range(0, 3);
          end else begin
            req = pending_bytes.pop_front();
            next_valid = 1'b1;
            s_tdata <= req.data;
            s_tuser <= req.start;
          end
        end
        s_tvalid <= next_valid;
      end
    end
  end

  // event monitor and output stalls
  always @(posedge clk) begin : watch
    s3mpu_pkg::res_t got;
    s3mpu_pkg::res_t want;
    if (rst) begin
      m_tready <= 1'b0;
      m_gap = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.event_valid = m_tuser[0];
        got.pattern_done = m_tlast;
        got.row_index = m_tdata[5:0];
        got.channel_index = m_tdata[10:6];
        got.note_value = m_tdata[18:11];
        got.note_trigger = m_tdata[19];
        got.instrument = m_tdata[28:20];
        got.volume = m_tdata[37:29];
        got.command_kind = m_tdata[42:38];
        got.command_arg1 = m_tdata[59:43];
        got.command_arg2 = m_tdata[68:60];
        if (pending_events.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %h", $time, got);
          mismatches++;
        end else begin
          want = pending_events.pop_front();
          check_field("event_valid", want.event_valid, got.event_valid);
          check_field("pattern_done", want.pattern_done, got.pattern_done);
          check_field("row_index", want.row_index, got.row_index);
          check_field("channel_index", want.channel_index, got.channel_index);
          check_field("note_value", want.note_value, got.note_value);
          check_field("note_trigger", want.note_trigger, got.note_trigger);
          check_field("instrument", want.instrument, got.instrument);
          check_field("volume", want.volume, got.volume);
          check_field("command_kind", want.command_kind, got.command_kind);
          check_field("command_arg1", want.command_arg1, got.command_arg1);
          check_field("command_arg2", want.command_arg2, got.command_arg2);
        end
      end
      if (m_gap > 0) begin
        m_gap--;
        m_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        m_gap = $urandom_range(0, 3);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // stimulus
  initial begin : stim
    logic [7:0] cfg_vals[5];
    int         target;
    int         n;
    cfg_vals[0] = 8'd0;
    cfg_vals[1] = 8'd255;
    cfg_vals[2] = 8'd1;
    cfg_vals[3] = 8'($urandom_range(2, 254));
    cfg_vals[4] = 8'd99;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes and special cases, all instruments allowed
    write_sample_count(8'd255);
    queue_byte(8'h25, 1'b0);                  // idle before any start: ignored
    queue_byte({3'b111, 5'd31}, 1'b1);        // all fields, top channel
    queue_byte(8'h9B, 1'b0);                  // octave 9, semitone 11
    queue_byte(8'hFF, 1'b0);                  // top instrument
    queue_byte(8'hFF, 1'b0);                  // top volume
    queue_byte(s3mpu_pkg::FX_S, 1'b0);
    queue_byte({s3mpu_pkg::SX_FINETUNE, 4'hF}, 1'b0);    // negative finetune
    queue_byte({3'b001, 5'd0}, 1'b0);         // note off, instrument zero
    queue_byte(s3mpu_pkg::NOTE_IN_OFF, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte({3'b010, 5'd1}, 1'b0);         // volume only, zero
    queue_byte(8'h00, 1'b0);
    queue_byte({3'b100, 5'd31}, 1'b0);        // speed with zero info
    queue_byte(s3mpu_pkg::FX_A, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte({3'b000, 5'd5}, 1'b0);         // mask without field bits
    queue_byte({3'b101, 5'd3}, 1'b0);         // empty note with portamento
    queue_byte(s3mpu_pkg::NOTE_IN_EMPTY, 1'b0);
    queue_byte(8'd7, 1'b0);
    queue_byte(s3mpu_pkg::FX_G, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte({3'b111, 5'd2}, 1'b0);         // event cut by a new start
    queue_byte(8'h45, 1'b0);
    queue_byte(8'h00, 1'b1);

    // random phases, one sample count each; the last without idling
    for (int ph = 0; ph < 5; ph++) begin
      wait_idle();
      write_sample_count(cfg_vals[ph]);
      if (ph == 4) quiet = 1'b1;
      target = bytes_queued + PHASE_BYTES;
      while (bytes_queued < target) begin
        case ($urandom_range(0, 9))
          5: queue_pattern(ROWS, 1);
          6, 7: begin
            // bare pattern, then a byte that must be ignored
            queue_pattern(ROWS, 0);
            queue_byte(8'($urandom_range(0, 255)), 1'b0);
          end
          8: begin
            // noise after a start, with the odd restart
            queue_byte(8'($urandom_range(0, 255)), 1'b1);
            n = $urandom_range(1, 10);
            repeat (n) queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
          end
          9: queue_event(1'b1, 1'b1);
          default: queue_pattern($urandom_range(1, 12), $urandom_range(0, 3));
        endcase
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### s3m_pattern_event_unpacker_core.f
+incdir+design
design/s3mpu_pkg.sv
design/s3mpu_front.sv
design/s3mpu_queue.sv
design/s3mpu_back.sv
design/s3m_pattern_event_unpacker_core.sv
tb/testbench.sv
